// ===== sv/cda_pkg.sv =====
// shared types, constants and calendar helper functions for the date advance block
package cda_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned YMOD_W  = 9;
  localparam int unsigned REM_W   = 17;

  localparam int unsigned FIRST_YEAR    = 1754;
  localparam int unsigned LAST_YEAR_DEF = 9999;
  // leap years in 1..1753
  localparam int unsigned LEAPS_BEFORE_FIRST = 425;

  localparam logic [DAY_W-1:0]   FIRST_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [YMOD_W-1:0]  FIRST_YMOD  = 9'd154;
  localparam logic [WDAY_W-1:0]  FIRST_WDAY  = 3'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

  // floor(x / 25) = (x * 1311) >> 15 for x below 4096
  localparam logic [10:0] RECIP_25    = 11'd1311;
  localparam int unsigned RECIP_SHIFT = 15;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [COUNT_W-1:0]   day_count;
    logic [DAY_W-1:0]     load_day;
    logic [MONTH_W-1:0]   load_month;
    logic [YEAR_W-1:0]    load_year;
  } cda_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]     cur_day;
    logic [MONTH_W-1:0]   cur_month;
    logic [YEAR_W-1:0]    cur_year;
    logic [WDAY_W-1:0]    weekday;
    logic                 error;
  } cda_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV_DOY,
    S_ADV_YEAR,
    S_ADV_MONTH,
    S_LD_MUL,
    S_LD_MOD,
    S_LD_CHK,
    S_LD_DOY,
    S_OUT
  } cda_state_e;

  // leap test on the year taken modulo 400
  function automatic logic is_leap(input logic [YMOD_W-1:0] ym);
    return (ym[1:0] == 2'd0) &&
           (ym == 9'd0 || (ym != 9'd100 && ym != 9'd200 && ym != 9'd300));
  endfunction

  function automatic logic [YMOD_W-1:0] year_len(input logic [YMOD_W-1:0] ym);
    return is_leap(ym) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // octal digits fold, since 8 is 1 modulo 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [17:0] x);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] u;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) +
        6'(x[17:15]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    u = 4'(t[2:0]) + 4'(t[3]);
    return (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
  endfunction

endpackage

// ===== sv/calendar_date_advance.sv =====
// Gregorian date register with weekday. An advance item walks the date forward
// by day_count days, a load item checks and stores a full date; each item gives
// one result with the date, weekday and an error flag (state kept on error).
// The block takes one item at a time and holds in_stall_o high while it works.
// All walking goes through one shared add/subtract unit with a month/year
// length lookup, one step per cycle: an advance first walks the months to find
// the day of year, then steps over whole years, then takes up to 12 month
// steps, registers the result and goes back to idle before the next item. A
// load does one reciprocal multiply for the leap-year count, a modulo step, a
// range check and the same month walk. A stalled result holds the block in its
// output step until it is taken.
module calendar_date_advance #(
  parameter int unsigned LastYear = cda_pkg::LAST_YEAR_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cda_pkg::cda_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cda_pkg::cda_out_t out_data_o
);
  import cda_pkg::*;

  cda_state_e state_q, state_d;

  // held date
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic [YMOD_W-1:0]  ymod_q;
  logic [WDAY_W-1:0]  wday_q;

  // working registers
  cda_in_t            in_q;
  logic [REM_W-1:0]   rem_q;
  logic [YEAR_W:0]    yr_q;
  logic [YMOD_W-1:0]  ym_q;
  logic [MONTH_W-1:0] k_q;
  logic [7:0]         q100_q;
  logic               err_q;

  cda_out_t           out_q;
  logic               out_valid_q;

  logic               in_accept;
  logic               out_load;
  logic               commit;

  // shared unit
  logic               leap_w;
  logic [YMOD_W-1:0]  len_w;
  logic               au_sub;
  logic [REM_W-1:0]   au_res;
  logic               au_ge;

  // load arithmetic
  logic [YEAR_W-1:0]  yy_w;
  logic [11:0]        q4_w;
  logic [22:0]        prod_w;
  logic [5:0]         q400_w;
  logic [YEAR_W-1:0]  r400_w;
  logic [YMOD_W-1:0]  ym_ld_w;
  logic [REM_W-1:0]   count_w;
  logic               bad_ld_w;

  logic [DAY_W-1:0]   new_day;
  logic [MONTH_W-1:0] new_month;
  logic [YEAR_W-1:0]  new_year;
  logic [WDAY_W-1:0]  new_wday;
  logic [WDAY_W-1:0]  w7_w;
  logic [3:0]         wsum_w;

  assign leap_w = is_leap(ym_q);
  assign au_sub = (state_q == S_ADV_YEAR) || (state_q == S_ADV_MONTH);
  assign au_res = au_sub ? rem_q - REM_W'(len_w) : rem_q + REM_W'(len_w);
  assign au_ge  = rem_q >= REM_W'(len_w);

  always_comb begin
    if (state_q == S_ADV_YEAR) begin
      len_w = year_len(ym_q);
    end else begin
      len_w = YMOD_W'(month_len(k_q, leap_w));
    end
  end

  assign yy_w    = in_q.load_year - 14'd1;
  assign q4_w    = yy_w[YEAR_W-1:2];
  assign prod_w  = 23'(q4_w) * 23'(RECIP_25);
  assign q400_w  = q100_q[7:2];
  assign r400_w  = yy_w - YEAR_W'(14'(q400_w) * 14'd400);
  assign ym_ld_w = (r400_w == 14'd399) ? '0 : YMOD_W'(r400_w + 14'd1);
  assign count_w = REM_W'(yy_w) - REM_W'(FIRST_YEAR - 1) + REM_W'(q4_w) -
                   REM_W'(q100_q) + REM_W'(q400_w) - REM_W'(LEAPS_BEFORE_FIRST);

  assign bad_ld_w = (in_q.load_month == '0) || (in_q.load_month > LAST_MONTH) ||
                    (in_q.load_year < YEAR_W'(FIRST_YEAR)) ||
                    ({1'b0, in_q.load_year} > (YEAR_W + 1)'(LastYear)) ||
                    (in_q.load_day == '0) ||
                    (in_q.load_day > month_len(in_q.load_month, leap_w));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (in_data_i.action == ACT_LOAD) ? S_LD_MUL : S_ADV_DOY;
        end
      end
      S_ADV_DOY: begin
        if (k_q >= month_q) state_d = S_ADV_YEAR;
      end
      S_ADV_YEAR: begin
        if (yr_q > (YEAR_W + 1)'(LastYear)) begin
          state_d = S_OUT;
        end else if (!au_ge) begin
          state_d = S_ADV_MONTH;
        end
      end
      S_ADV_MONTH: begin
        if (!(k_q < LAST_MONTH && au_ge)) state_d = S_OUT;
      end
      S_LD_MUL: state_d = S_LD_MOD;
      S_LD_MOD: state_d = S_LD_CHK;
      S_LD_CHK: state_d = bad_ld_w ? S_OUT : S_LD_DOY;
      S_LD_DOY: begin
        if (k_q >= in_q.load_month) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs and commit values
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_accept  = in_valid_i && (state_q == S_IDLE);
    out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
    commit     = 1'b0;
    new_day    = in_q.load_day;
    new_month  = in_q.load_month;
    new_year   = in_q.load_year;
    new_wday   = wday_q;
    w7_w       = mod7(18'(rem_q));
    wsum_w     = 4'(wday_q) + 4'(mod7(18'(in_q.day_count)));
    unique case (state_q)
      S_ADV_MONTH: begin
        if (!(k_q < LAST_MONTH && au_ge)) begin
          commit    = 1'b1;
          new_day   = rem_q[DAY_W-1:0] + 5'd1;
          new_month = k_q;
          new_year  = yr_q[YEAR_W-1:0];
          new_wday  = (wsum_w >= 4'd7) ? 3'(wsum_w - 4'd7) : wsum_w[2:0];
        end
      end
      S_LD_DOY: begin
        if (k_q >= in_q.load_month) begin
          commit   = 1'b1;
          new_wday = (w7_w == 3'd6) ? 3'd0 : w7_w + 3'd1;
        end
      end
      default: commit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      day_q       <= FIRST_DAY;
      month_q     <= FIRST_MONTH;
      year_q      <= YEAR_W'(FIRST_YEAR);
      ymod_q      <= FIRST_YMOD;
      wday_q      <= FIRST_WDAY;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        day_q   <= new_day;
        month_q <= new_month;
        year_q  <= new_year;
        ymod_q  <= ym_q;
        wday_q  <= new_wday;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{cur_day: day_q, cur_month: month_q, cur_year: year_q,
                 weekday: wday_q, error: err_q};
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          in_q  <= in_data_i;
          rem_q <= REM_W'(in_data_i.day_count) + REM_W'(day_q) - 17'd1;
          k_q   <= 4'd1;
          yr_q  <= {1'b0, year_q};
          ym_q  <= ymod_q;
          err_q <= 1'b0;
        end
      end
      S_ADV_DOY: begin
        if (k_q < month_q) begin
          rem_q <= au_res;
          k_q   <= k_q + 4'd1;
        end
      end
      S_ADV_YEAR: begin
        if (yr_q > (YEAR_W + 1)'(LastYear)) begin
          err_q <= 1'b1;
        end else if (au_ge) begin
          rem_q <= au_res;
          yr_q  <= yr_q + 15'd1;
          ym_q  <= (ym_q == 9'd399) ? '0 : ym_q + 9'd1;
        end else begin
          k_q <= 4'd1;
        end
      end
      S_ADV_MONTH: begin
        if (k_q < LAST_MONTH && au_ge) begin
          rem_q <= au_res;
          k_q   <= k_q + 4'd1;
        end
      end
      S_LD_MUL: q100_q <= prod_w[22:RECIP_SHIFT];
      S_LD_MOD: begin
        ym_q  <= ym_ld_w;
        rem_q <= count_w;
      end
      S_LD_CHK: begin
        err_q <= bad_ld_w;
        k_q   <= 4'd1;
        rem_q <= REM_W'(mod7(18'(rem_q))) + REM_W'(in_q.load_day) - 17'd1;
      end
      S_LD_DOY: begin
        if (k_q < in_q.load_month) begin
          rem_q <= au_res;
          k_q   <= k_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    month_q >= 4'd1 && month_q <= LAST_MONTH && day_q != '0 && wday_q <= 3'd6)
    else $error("held date out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result shown outside the output step");

endmodule

// ===== sim/tb_calendar_date_advance.sv =====
// self-checking testbench for the calendar date advance block
module tb_calendar_date_advance;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int unsigned LAST_YEAR = LAST_YEAR_DEF;
  localparam int unsigned TAIL_CYCLES = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cda_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  cda_out_t out_data;

  // date the block should hold after the items accepted so far
  int unsigned cal_day = 1;
  int unsigned cal_month = 1;
  int unsigned cal_year = FIRST_YEAR;
  int unsigned cal_wday = 1;

  cda_out_t expected_dates[$];
  int       mismatch_cnt = 0;
  bit       src_idle_en = 1'b1;
  bit       snk_idle_en = 1'b1;
  int       hold_req = 0;
  int       hold_cnt = 0;
  int       stall_burst = 0;

  calendar_date_advance #(
    .LastYear(LAST_YEAR)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      2:           len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic int unsigned leaps_through(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // zero-based day within the year
  function automatic int unsigned yday(int unsigned d, int unsigned m, int unsigned y);
    int unsigned acc;
    acc = d - 1;
    for (int unsigned k = 1; k < m; k++) acc += days_in_month(k, y);
    return acc;
  endfunction

  function automatic int unsigned epoch_days(int unsigned d, int unsigned m, int unsigned y);
    return 365 * (y - FIRST_YEAR) + leaps_through(y - 1) - leaps_through(FIRST_YEAR - 1) +
           yday(d, m, y);
  endfunction

  // applies one item to the predicted date and returns the expected result
  function automatic cda_out_t apply_item(cda_in_t it);
    int unsigned rem;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    bit          bad;
    cda_out_t    res;
    bad = 1'b0;
    if (it.action == ACT_ADVANCE) begin
      rem = it.day_count + yday(cal_day, cal_month, cal_year);
      y = cal_year;
      while (rem >= days_in_year(y) && y <= LAST_YEAR) begin
        rem -= days_in_year(y);
        y++;
      end
      if (y > LAST_YEAR) begin
        bad = 1'b1;
      end else begin
        m = 1;
        while (m < 12 && rem >= days_in_month(m, y)) begin
          rem -= days_in_month(m, y);
          m++;
        end
        cal_day = rem + 1;
        cal_month = m;
        cal_year = y;
        cal_wday = (cal_wday + it.day_count) % 7;
      end
    end else begin
      d = it.load_day;
      m = it.load_month;
      y = it.load_year;
      if (m < 1 || m > 12 || y < FIRST_YEAR || y > LAST_YEAR || d < 1 ||
          d > days_in_month(m, y)) begin
        bad = 1'b1;
      end else begin
        cal_day = d;
        cal_month = m;
        cal_year = y;
        cal_wday = (epoch_days(d, m, y) + 1) % 7;
      end
    end
    res.cur_day = DAY_W'(cal_day);
    res.cur_month = MONTH_W'(cal_month);
    res.cur_year = YEAR_W'(cal_year);
    res.weekday = WDAY_W'(cal_wday);
    res.error = bad;
    return res;
  endfunction

  // every field random, so unused fields toggle too
  function automatic cda_in_t noise_item();
    cda_in_t it;
    it.action = 1'($urandom);
    it.day_count = COUNT_W'($urandom);
    it.load_day = DAY_W'($urandom);
    it.load_month = MONTH_W'($urandom);
    it.load_year = YEAR_W'($urandom);
    return it;
  endfunction

  function automatic cda_in_t adv(int unsigned n);
    cda_in_t it;
    it = noise_item();
    it.action = ACT_ADVANCE;
    it.day_count = COUNT_W'(n);
    return it;
  endfunction

  function automatic cda_in_t ld(int unsigned d, int unsigned m, int unsigned y);
    cda_in_t it;
    it = noise_item();
    it.action = ACT_LOAD;
    it.load_day = DAY_W'(d);
    it.load_month = MONTH_W'(m);
    it.load_year = YEAR_W'(y);
    return it;
  endfunction

  function automatic cda_in_t random_item();
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (cal_year > LAST_YEAR - 200 && $urandom_range(0, 1) == 0)
        return adv($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
        0, 1, 2: return adv($urandom_range(0, 400));
        3, 4:    return adv($urandom_range(0, 4000));
        default: return adv($urandom_range(0, 65535));
      endcase
    end
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(0, 1) ? $urandom_range(FIRST_YEAR, FIRST_YEAR + 6)
                                        : $urandom_range(LAST_YEAR - 9, LAST_YEAR);
      1:       y = 100 * $urandom_range(18, LAST_YEAR / 100) - 4 + $urandom_range(0, 8);
      default: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
    endcase
    if (y > LAST_YEAR) y = LAST_YEAR;
    m = $urandom_range(1, 12);
    if (pick < 75) return ld($urandom_range(1, days_in_month(m, y)), m, y);
    // day right at or just past the month's end
    if (pick < 90) return ld(days_in_month(m, y) + $urandom_range(0, 1), m, y);
    return noise_item();
  endfunction

  task automatic send_item(cda_in_t it);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    expected_dates.push_back(apply_item(it));
  endtask

  task automatic wait_all_dates();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_dates.size() != 0);
  endtask

  task automatic test_directed();
    send_item(ld(1, 1, FIRST_YEAR));
    send_item(adv(0));
    send_item(adv(1));
    send_item(adv(65535));
    send_item(ld(29, 2, 2000));
    send_item(ld(29, 2, 1900));
    send_item(ld(29, 2, 2004));
    send_item(ld(31, 4, 2021));
    send_item(ld(30, 4, 2021));
    send_item(ld(0, 5, 2020));
    send_item(ld(31, 0, 2020));
    send_item(ld(1, 13, 2020));
    send_item(ld(31, 15, 16383));
    send_item(ld(1, 1, FIRST_YEAR - 1));
    send_item(ld(1, 1, LAST_YEAR + 1));
    send_item(ld(28, 2, 2023));
    send_item(adv(1));
    send_item(ld(31, 12, 1799));
    send_item(adv(1));
    // walk onto the last day, then past it
    send_item(ld(1, 1, LAST_YEAR));
    send_item(adv(364));
    send_item(adv(0));
    send_item(adv(1));
    send_item(ld(31, 12, LAST_YEAR));
    send_item(adv(65535));
  endtask

  task automatic test_random(int num);
    repeat (num) send_item(random_item());
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_hold();
    hold_req = 400;
    repeat (8) send_item(random_item());
  endtask

  task automatic test_drain_pause();
    repeat (10) send_item(random_item());
    wait_all_dates();
    repeat (10) send_item(random_item());
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (stall_burst != 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_burst = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cda_out_t exp_res;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result %0d.%0d.%0d wd %0d err %0b", out_data.cur_day,
                   out_data.cur_month, out_data.cur_year, out_data.weekday, out_data.error);
      end else begin
        exp_res = expected_dates.pop_front();
        if (out_data.cur_day !== exp_res.cur_day || out_data.cur_month !== exp_res.cur_month ||
            out_data.cur_year !== exp_res.cur_year || out_data.weekday !== exp_res.weekday ||
            out_data.error !== exp_res.error) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %0d.%0d.%0d wd %0d err %0b, got %0d.%0d.%0d wd %0d err %0b",
                     exp_res.cur_day, exp_res.cur_month, exp_res.cur_year, exp_res.weekday,
                     exp_res.error, out_data.cur_day, out_data.cur_month, out_data.cur_year,
                     out_data.weekday, out_data.error);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_output_hold();
    test_drain_pause();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random(120);
    wait_all_dates();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_dates.size() == 0) begin
      $display("tb_calendar_date_advance passed");
    end else begin
      $display("tb_calendar_date_advance failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_calendar_date_advance failed");
    $finish;
  end

endmodule
